FILE: rtl/stq_pkg.sv
// Package for the sorted timeout queue: beat structs, request and result
// codes, cell commands and default sizes. No dependencies.
`default_nettype none

package stq_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  // At most this many expiries leave on one tick.
  localparam int unsigned MAX_EMIT  = 16;
  localparam int unsigned EMIT_BITS = $clog2(MAX_EMIT);

  typedef enum logic [1:0] {
    REQ_WATCH  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED    = 2'd0,
    KIND_REJECTED    = 2'd1,
    KIND_CANCEL_DONE = 2'd2,
    KIND_EXPIRED     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] id;
    logic [23:0] timeout;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_id;
    logic [31:0] expired_at;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/stq_cell.sv
// One slot of the sorted timeout queue: holds an id and its expiry, and
// shifts with its neighbours on remove, insert and pop. Uses stq_pkg.
`default_nettype none

module stq_cell #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  stq_pkg::cmd_e       cmd_i,
  input  wire [ID_BITS-1:0]   key_id_i,
  input  wire [TIME_BITS-1:0] new_exp_i,
  input  wire                 left_valid_i,
  input  wire [ID_BITS-1:0]   left_id_i,
  input  wire [TIME_BITS-1:0] left_exp_i,
  input  wire                 right_valid_i,
  input  wire [ID_BITS-1:0]   right_id_i,
  input  wire [TIME_BITS-1:0] right_exp_i,
  input  wire                 chain_i,
  output logic                chain_o,
  output logic                valid_o,
  output logic [ID_BITS-1:0]  id_o,
  output logic [TIME_BITS-1:0] exp_o
);
  import stq_pkg::*;

  logic                 valid_q, valid_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  logic [TIME_BITS-1:0] diff;
  logic                 hit;

  // Wrap-safe: new expiry lies before ours when the difference is negative.
  assign diff = new_exp_i - exp_q;

  always_comb begin
    unique case (cmd_i)
      CMD_REMOVE: hit = valid_q && (id_q == key_id_i);
      CMD_INSERT: hit = !valid_q || diff[TIME_BITS-1];
      default:    hit = 1'b0;
    endcase
  end

  assign chain_o = chain_i | hit;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    exp_d   = exp_q;
    unique case (cmd_i)
      CMD_HOLD: begin
      end
      CMD_REMOVE: begin
        // Close the gap: everything from the match onwards moves left.
        if (chain_o) begin
          valid_d = right_valid_i;
          id_d    = right_id_i;
          exp_d   = right_exp_i;
        end
      end
      CMD_INSERT: begin
        if (chain_i) begin
          valid_d = left_valid_i;
          id_d    = left_id_i;
          exp_d   = left_exp_i;
        end else if (hit) begin
          valid_d = 1'b1;
          id_d    = key_id_i;
          exp_d   = new_exp_i;
        end
      end
      CMD_POP: begin
        valid_d = right_valid_i;
        id_d    = right_id_i;
        exp_d   = right_exp_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    exp_q <= exp_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign exp_o   = exp_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_timeout_queue_top.sv
// Top level of the sorted timeout queue: control sequencer, time counter,
// output register and a chain of stq_cell slots. Uses stq_pkg and stq_cell.
`default_nettype none

// Channel   Direction  Handshake                 Beat
// --------  ---------  ------------------------  ---------------------------
// request   in         in_valid_i / in_ready_o   stq_pkg::in_t  (in_data_i)
// result    out        out_valid_o / out_ready_i stq_pkg::out_t (out_data_o)
//
// Steps: a cancel passes accept, remove pass and response; a watch passes accept,
// remove pass, insert pass and response. A tick advances the time, then the head
// slot emits one expiry beat a cycle while the result register can take it.
// Requests are taken one at a time; in_ready_o is high only while idle.
// A held result beat stalls the response and each expiry until it leaves; a new
// request may still be taken while it waits. Reset clears slot valid bits, count, time.

module sorted_timeout_queue_top #(
  parameter int unsigned CAPACITY  = stq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS   = stq_pkg::ID_BITS_DEF,
  parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  stq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output stq_pkg::out_t out_data_o
);
  import stq_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REMOVE = 5'b00010,
    S_INSERT = 5'b00100,
    S_RESP   = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic                 watch_q, watch_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [EMIT_BITS-1:0] emit_q, emit_d;
  kind_e                kind_q, kind_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  cmd_e                 cmd;
  logic                 slot_free;

  // Padded neighbour rows: cell g lives at index g+1, both ends read empty.
  logic                 cv [CAPACITY+2];
  logic [ID_BITS-1:0]   cid [CAPACITY+2];
  logic [TIME_BITS-1:0] cexp [CAPACITY+2];
  logic                 chain [CAPACITY+1];

  assign cv[0]            = 1'b0;
  assign cid[0]           = '0;
  assign cexp[0]          = '0;
  assign cv[CAPACITY+1]   = 1'b0;
  assign cid[CAPACITY+1]  = '0;
  assign cexp[CAPACITY+1] = '0;
  assign chain[0]         = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    stq_cell #(
      .ID_BITS  (ID_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_id_i     (id_q),
      .new_exp_i    (exp_q),
      .left_valid_i (cv[g]),
      .left_id_i    (cid[g]),
      .left_exp_i   (cexp[g]),
      .right_valid_i(cv[g+2]),
      .right_id_i   (cid[g+2]),
      .right_exp_i  (cexp[g+2]),
      .chain_i      (chain[g]),
      .chain_o      (chain[g+1]),
      .valid_o      (cv[g+1]),
      .id_o         (cid[g+1]),
      .exp_o        (cexp[g+1])
    );
  end

  // Expiry tests on the head and the slot behind it, wrap-safe.
  logic [TIME_BITS-1:0] head_diff, next_diff;
  logic                 head_due, next_due, drain_last;

  assign head_diff  = time_q - cexp[1];
  assign next_diff  = time_q - cexp[2];
  assign head_due   = cv[1] && !head_diff[TIME_BITS-1];
  assign next_due   = cv[2] && !next_diff[TIME_BITS-1];
  assign drain_last = (emit_q == EMIT_BITS'(MAX_EMIT - 1)) || !next_due;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    watch_d     = watch_q;
    id_d        = id_q;
    exp_d       = exp_q;
    time_d      = time_q;
    count_d     = count_q;
    emit_d      = emit_q;
    kind_d      = kind_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = CMD_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d  = ID_BITS'(in_data_i.id);
          exp_d = time_q + TIME_BITS'(in_data_i.timeout);
          unique case (in_data_i.req_type)
            REQ_WATCH: begin
              watch_d = 1'b1;
              state_d = S_REMOVE;
            end
            REQ_CANCEL: begin
              watch_d = 1'b0;
              state_d = S_REMOVE;
            end
            REQ_TICK: begin
              time_d  = time_q + 1'b1;
              emit_d  = '0;
              state_d = S_DRAIN;
            end
            default: begin
              // Unused request code: drop it.
            end
          endcase
        end
      end

      S_REMOVE: begin
        cmd = CMD_REMOVE;
        if (chain[CAPACITY]) begin
          count_d = count_q - 1'b1;
        end
        if (watch_q) begin
          state_d = S_INSERT;
        end else begin
          kind_d  = KIND_CANCEL_DONE;
          state_d = S_RESP;
        end
      end

      S_INSERT: begin
        if (count_q == CNT_BITS'(CAPACITY)) begin
          kind_d = KIND_REJECTED;
        end else begin
          cmd     = CMD_INSERT;
          count_d = count_q + 1'b1;
          kind_d  = KIND_ACCEPTED;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.kind       = kind_q;
          out_d.out_id     = 16'(id_q);
          out_d.expired_at = '0;
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_DRAIN: begin
        if (!head_due) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_EXPIRED;
          out_d.out_id     = 16'(cid[1]);
          out_d.expired_at = 32'(cexp[1]);
          out_d.last       = drain_last;
          cmd              = CMD_POP;
          count_d          = count_q - 1'b1;
          emit_d           = emit_q + 1'b1;
          if (drain_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    watch_q <= watch_d;
    id_q    <= id_d;
    exp_q   <= exp_d;
    emit_q  <= emit_d;
    kind_q  <= kind_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/stq_checker.sv
// Port-level checks for the sorted timeout queue, bound to the top level.
// Uses stq_pkg.
`default_nettype none

module stq_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_i,
  input stq_pkg::in_t  in_data_i,
  input wire           out_valid_i,
  input wire           out_ready_i,
  input stq_pkg::out_t out_data_i
);
  import stq_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // Watch and cancel answers are single beats without a time.
  a_resp_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.kind != KIND_EXPIRED)
      |-> out_data_i.last && (out_data_i.expired_at == '0))
    else $error("watch or cancel result malformed");

  // Watch and cancel need a search pass before the next request.
  a_busy_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
      (in_data_i.req_type == REQ_WATCH || in_data_i.req_type == REQ_CANCEL)
      |=> !in_ready_i)
    else $error("request taken during search pass");

  // A tick always checks the head before the next request.
  a_busy_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_data_i.req_type == REQ_TICK)
      |=> !in_ready_i)
    else $error("request taken during expiry check");

endmodule

bind sorted_timeout_queue_top stq_checker u_stq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

`default_nettype wire

FILE: sim/stq_result_checker.sv
// Result checker for the sorted timeout queue: watches both channels, keeps
// its own timer list and compares every result beat. Depends on stq_pkg.
`timescale 1ns / 100ps

module stq_result_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_ready_i,
  input  stq_pkg::in_t       in_data_i,
  input  wire                out_valid_i,
  input  wire                out_ready_i,
  input  stq_pkg::out_t      out_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import stq_pkg::*;

  localparam int unsigned SLOTS = CAPACITY_DEF;

  logic [31:0]  now_ticks;
  logic [15:0]  slot_id  [SLOTS];
  logic [31:0]  slot_exp [SLOTS];
  int unsigned  slot_count;
  out_t         awaited_results [$];
  out_t         oldest;
  int unsigned  fails;

  // Wrap-safe ordering: a lies before b when a - b has its top bit set.
  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic void drop_slots(int unsigned pos, int unsigned n);
    for (int unsigned i = pos; i + n < slot_count; i++) begin
      slot_id[i]  = slot_id[i + n];
      slot_exp[i] = slot_exp[i + n];
    end
    slot_count -= n;
  endfunction

  function automatic void forget_id(logic [15:0] id);
    for (int unsigned i = 0; i < slot_count; i++) begin
      if (slot_id[i] == id) begin
        drop_slots(i, 1);
        return;
      end
    end
  endfunction

  function automatic void await_result(kind_e kind, logic [15:0] id,
                                       logic [31:0] at, logic last);
    out_t r;
    r.kind       = kind;
    r.out_id     = id;
    r.expired_at = at;
    r.last       = last;
    awaited_results = {awaited_results, r};
  endfunction

  function automatic void predict_timer_request(in_t beat);
    logic [31:0] due;
    int unsigned pos;
    int unsigned n;
    case (beat.req_type)
      REQ_WATCH: begin
        forget_id(beat.id);
        if (slot_count >= SLOTS) begin
          await_result(KIND_REJECTED, beat.id, '0, 1'b1);
        end else begin
          due = now_ticks + 32'(beat.timeout);
          pos = slot_count;
          // Equal expirations keep arrival order: insert after them.
          for (int unsigned i = 0; i < slot_count; i++) begin
            if (earlier(due, slot_exp[i])) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = slot_count; i > pos; i--) begin
            slot_id[i]  = slot_id[i - 1];
            slot_exp[i] = slot_exp[i - 1];
          end
          slot_id[pos]  = beat.id;
          slot_exp[pos] = due;
          slot_count++;
          await_result(KIND_ACCEPTED, beat.id, '0, 1'b1);
        end
      end
      REQ_CANCEL: begin
        forget_id(beat.id);
        await_result(KIND_CANCEL_DONE, beat.id, '0, 1'b1);
      end
      REQ_TICK: begin
        now_ticks = now_ticks + 32'd1;
        n = 0;
        while (n < slot_count && n < MAX_EMIT && !earlier(now_ticks, slot_exp[n])) n++;
        for (int unsigned k = 0; k < n; k++) begin
          await_result(KIND_EXPIRED, slot_id[k], slot_exp[k], k + 1 == n);
        end
        if (n > 0) drop_slots(0, n);
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endfunction

  // Result side first: a beat leaving now never belongs to a request taken now.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      now_ticks  = '0;
      slot_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat expected none, got %h", $time, out_data_i);
          fails++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("kind", 32'(oldest.kind), 32'(out_data_i.kind));
          compare_field("out_id", 32'(oldest.out_id), 32'(out_data_i.out_id));
          compare_field("expired_at", oldest.expired_at, out_data_i.expired_at);
          compare_field("last", 32'(oldest.last), 32'(out_data_i.last));
        end
      end
      if (in_valid_i && in_ready_i) predict_timer_request(in_data_i);
      pending_o    = awaited_results.size();
      fail_count_o = fails;
    end
  end

endmodule

FILE: sim/sorted_timeout_queue_top_tb.sv
// Testbench top for the sorted timeout queue: clock, reset, request stimulus
// and result back-pressure, verdict. Uses stq_pkg and stq_result_checker.
`timescale 1ns / 100ps

module sorted_timeout_queue_top_tb;
  import stq_pkg::*;

  // The spare request code: the block must swallow it without a result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned ID_POOL         = 23;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  in_t         in_data;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int unsigned idle_pct;
  int unsigned stall_pct;

  sorted_timeout_queue_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  stq_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Back-pressure: redraw ready on every falling edge, so stalls can land on
  // any beat of a burst of expiries.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Present one request beat. Gaps come first, so valid is only lowered when
  // the sender actually idles; once raised it holds until the beat is taken.
  task automatic issue(input logic [1:0] req, input logic [15:0] id,
                       input logic [23:0] tmo);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.req_type <= req;
    in_data.id       <= id;
    in_data.timeout  <= tmo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random request: ids mostly from a small pool so that re-watches and
  // cancels hit queued entries; timeouts mostly short so ticks expire them,
  // with a few long ones that pile up and push the queue towards full.
  task automatic issue_random(output logic [1:0] req);
    int unsigned pick;
    logic [15:0] id;
    logic [23:0] tmo;
    pick = $urandom_range(0, 99);
    id   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, ID_POOL));
    case ($urandom_range(0, 9))
      0:       tmo = 24'($urandom);
      1, 2:    tmo = 24'($urandom_range(0, 200));
      default: tmo = 24'($urandom_range(0, 12));
    endcase
    if (pick < 2)       req = REQ_UNUSED;
    else if (pick < 50) req = REQ_WATCH;
    else if (pick < 68) req = REQ_CANCEL;
    else                req = REQ_TICK;
    issue(req, id, tmo);
  endtask

  initial begin
    int unsigned sent;
    logic [1:0]  req;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty tick, spare code, cancel of an absent id.
    issue(REQ_TICK, 16'h0000, 24'h000000);
    issue(REQ_UNUSED, 16'hFFFF, 24'hFFFFFF);
    issue(REQ_CANCEL, 16'h0000, 24'h000000);
    // Zero and maximum timeouts at the extreme ids; re-watch moves an entry
    // and lands it behind an equal expiration.
    issue(REQ_WATCH, 16'h0000, 24'h000000);
    issue(REQ_WATCH, 16'hFFFF, 24'hFFFFFF);
    issue(REQ_WATCH, 16'h1234, 24'h000001);
    issue(REQ_WATCH, 16'h1234, 24'h000000);
    issue(REQ_TICK, 16'h0000, 24'h000000);
    issue(REQ_CANCEL, 16'hFFFF, 24'h000000);
    // Fill to capacity, bounce a new id, re-watch a queued id while full,
    // then let all sixteen expire on a single tick.
    for (int unsigned k = 0; k < CAPACITY_DEF; k++) begin
      issue(REQ_WATCH, 16'h0100 + 16'(k), 24'h000002);
    end
    issue(REQ_WATCH, 16'h0200, 24'h000002);
    issue(REQ_WATCH, 16'h0100, 24'h000002);
    issue(REQ_TICK, 16'h0000, 24'h000000);
    issue(REQ_TICK, 16'h0000, 24'h000000);

    // Random phases: free running, idle sender, stalling receiver, both.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 81; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        issue_random(req);
        if (req != REQ_UNUSED) sent++;
      end
    end

    // Drop valid, open the receiver and drain whatever is still owed.
    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sorted_timeout_queue_top.f
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timeout_queue_top.sv
rtl/stq_checker.sv
sim/stq_result_checker.sv
sim/sorted_timeout_queue_top_tb.sv
